/* rtl/core/range_remap_eased_macros.svh */
`ifndef RANGE_REMAP_EASED_MACROS_SVH
`define RANGE_REMAP_EASED_MACROS_SVH

// same-cycle implication
`define RRE_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("range_remap_eased: implication failed");

// fixed-latency implication
`define RRE_ASSERT_LAT(lbl, clk, rst_n, a, n, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
		else $error("range_remap_eased: latency check failed");

`endif

/* rtl/core/rrem_pkg.sv */
package rrem_pkg;

	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 16;

	typedef enum logic [2:0] {
		REG_INPUT_LOW    = 3'd0,
		REG_INPUT_HIGH   = 3'd1,
		REG_OUTPUT_LOW   = 3'd2,
		REG_OUTPUT_HIGH  = 3'd3,
		REG_CURVE_MODE   = 3'd4,
		REG_CLAMP_ENABLE = 3'd5
	} rrem_reg_t;

	typedef enum logic [2:0] {
		CURVE_STEP     = 3'd0,
		CURVE_LINEAR   = 3'd1,
		CURVE_SMOOTH   = 3'd2,
		CURVE_EASE_IN  = 3'd3,
		CURVE_EASE_OUT = 3'd4
	} rrem_curve_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_INVALID   = 2'd1;
	localparam logic [1:0] STATUS_SATURATED = 2'd2;

	typedef struct packed {
		logic valid;
		logic neg;
		logic ovf;
		logic invalid;
	} rrem_ctl_t;

endpackage

/* rtl/core/rrem_div_cell.sv */
module rrem_div_cell #(
	parameter int RW    = 56,
	parameter int DW    = 32,
	parameter int QB    = 24,
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DW-1:0]      divisor,
	input  logic [RW-1:0]      rem_in,
	input  logic [QB-1:0]      q_in,
	input  rrem_pkg::rrem_ctl_t ctl_in,
	output logic [RW-1:0]      rem_out,
	output logic [QB-1:0]      q_out,
	output rrem_pkg::rrem_ctl_t ctl_out
);

	logic [RW-1:0] trial;
	logic          ge;

	assign trial = {{(RW-DW){1'b0}}, divisor} << SHIFT;
	assign ge    = rem_in >= trial;

	always_ff @(posedge clk) begin
		rem_out <= ge ? rem_in - trial : rem_in;
		q_out   <= q_in | ({{(QB-1){1'b0}}, ge} << SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

endmodule

/* rtl/core/rrem_shape.sv */
module rrem_shape #(
	parameter int FB  = 16,
	parameter int AW  = FB + 8,
	parameter int SQW = 2 * AW - FB,
	parameter int SHW = SQW + AW + 3 - FB
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            mode,
	input  logic                  clamp,
	input  logic [AW-1:0]         mag_in,
	input  rrem_pkg::rrem_ctl_t   ctl_in,
	output logic signed [SHW-1:0] shaped_s4,
	output rrem_pkg::rrem_ctl_t   ctl_s4
);

	localparam logic [AW-1:0] LIMIT = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [AW-1:0] ONE_A = {{(AW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic signed [AW:0] ONE_B = {{(AW-FB){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic signed [AW+1:0] THREE = {{(AW-FB){1'b0}}, 2'b11, {FB{1'b0}}};
	localparam logic signed [SHW-1:0] ONE_S = {{(SHW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam int PRW = SQW + AW + 3;

	logic signed [AW-1:0]  amt_raw, amt_cl;
	logic signed [AW-1:0]  amt_s1, amt_s2, amt_s3;
	logic signed [AW:0]    base;
	logic [AW-1:0]         base_mag;
	logic [2*AW-1:0]       sq_full;
	logic [SQW-1:0]        sq_s2, sq_s3;
	logic signed [AW+1:0]  fac;
	logic signed [PRW-1:0] prod_s3;
	logic signed [SHW-1:0] shaped;
	rrem_pkg::rrem_ctl_t   ctl_s1, ctl_s2, ctl_s3;

	always_comb begin
		if (ctl_in.neg) begin
			amt_raw = (ctl_in.ovf || mag_in > LIMIT) ? AMIN : $signed(-mag_in);
		end else begin
			amt_raw = (ctl_in.ovf || mag_in >= LIMIT) ? AMAX : $signed(mag_in);
		end
		amt_cl = amt_raw;
		if (clamp) begin
			if (amt_raw < 0) begin
				amt_cl = '0;
			end else if (amt_raw > ONE_A) begin
				amt_cl = ONE_A;
			end
		end
	end

	always_comb begin
		if (mode == rrem_pkg::CURVE_EASE_OUT) begin
			base = ONE_B - {amt_s1[AW-1], amt_s1};
		end else begin
			base = {amt_s1[AW-1], amt_s1};
		end
		base_mag = base[AW] ? AW'(-base) : base[AW-1:0];
		sq_full  = base_mag * base_mag;
	end

	assign fac = THREE - ({{2{amt_s2[AW-1]}}, amt_s2} <<< 1);

	always_comb begin
		case (mode)
			rrem_pkg::CURVE_STEP:     shaped = (amt_s3 < ONE_A) ? '0 : ONE_S;
			rrem_pkg::CURVE_SMOOTH:   shaped = prod_s3[PRW-1:FB];
			rrem_pkg::CURVE_EASE_IN:  shaped = {{(SHW-SQW){1'b0}}, sq_s3};
			rrem_pkg::CURVE_EASE_OUT: shaped = ONE_S - {{(SHW-SQW){1'b0}}, sq_s3};
			default:                  shaped = {{(SHW-AW){amt_s3[AW-1]}}, amt_s3};
		endcase
	end

	always_ff @(posedge clk) begin
		amt_s1    <= amt_cl;
		amt_s2    <= amt_s1;
		sq_s2     <= sq_full[2*AW-1:FB];
		amt_s3    <= amt_s2;
		sq_s3     <= sq_s2;
		prod_s3   <= $signed({1'b0, sq_s2}) * fac;
		shaped_s4 <= shaped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

endmodule

/* rtl/core/rrem_blend.sv */
module rrem_blend #(
	parameter int VW  = 32,
	parameter int FB  = 16,
	parameter int SHW = 43
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [VW-1:0]  out_low,
	input  logic signed [VW-1:0]  out_high,
	input  logic signed [SHW-1:0] shaped,
	input  rrem_pkg::rrem_ctl_t   ctl_in,
	output logic                  done,
	output logic signed [VW-1:0]  mapped_value,
	output logic [1:0]            map_status
);

	localparam int LB  = SHW / 2;
	localparam int HB  = SHW - LB;
	localparam int PW  = VW + 1 + SHW;
	localparam int SW  = PW - FB + 1;
	localparam logic signed [SW-1:0] MAXV = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};

	logic signed [VW:0]       dout;
	logic signed [VW+LB+1:0]  plo_s1;
	logic signed [VW+HB:0]    phi_s1;
	logic signed [PW-1:0]     sum;
	logic signed [PW-FB-1:0]  scaled_s2;
	logic signed [SW-1:0]     total;
	rrem_pkg::rrem_ctl_t      ctl_s1, ctl_s2;

	assign dout = {out_high[VW-1], out_high} - {out_low[VW-1], out_low};
	assign sum  = $signed({phi_s1, {LB{1'b0}}})
		+ $signed({{(HB-1){plo_s1[VW+LB+1]}}, plo_s1});
	assign total = $signed({{(SW-PW+FB){scaled_s2[PW-FB-1]}}, scaled_s2})
		+ $signed({{(SW-VW){out_low[VW-1]}}, out_low});

	always_ff @(posedge clk) begin
		plo_s1    <= dout * $signed({1'b0, shaped[LB-1:0]});
		phi_s1    <= dout * $signed(shaped[SHW-1:LB]);
		scaled_s2 <= sum[PW-1:FB];
		if (ctl_s2.invalid) begin
			mapped_value <= '0;
			map_status   <= rrem_pkg::STATUS_INVALID;
		end else if (total > MAXV) begin
			mapped_value <= MAXV[VW-1:0];
			map_status   <= rrem_pkg::STATUS_SATURATED;
		end else if (total < MINV) begin
			mapped_value <= MINV[VW-1:0];
			map_status   <= rrem_pkg::STATUS_SATURATED;
		end else begin
			mapped_value <= total[VW-1:0];
			map_status   <= rrem_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			done   <= ctl_s2.valid;
		end
	end

endmodule

/* rtl/core/range_remap_eased.sv */
// channel   ports                                   handshake
// request   start, busy, sample                     start & !busy
// result    done, mapped_value, map_status          done, one cycle
// config    wr_en, wr_index, wr_data                wr_en
//
// One request per cycle; busy stays low.
// Each request passes through an input register, the row of
// divider cells, one quotient bit each, then shaping and blending stages.
// Reset clears the configuration to its defaults and empties the pipeline.
// Results leave on done without back-pressure.
`include "range_remap_eased_macros.svh"

module range_remap_eased #(
	parameter int VALUE_WIDTH   = rrem_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = rrem_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] sample,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] mapped_value,
	output logic [1:0]                    map_status,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [VALUE_WIDTH-1:0]        wr_data
);

	localparam int VW  = VALUE_WIDTH;
	localparam int FB  = FRACTION_BITS;
	localparam int AW  = FB + 8;
	localparam int QB  = AW;
	localparam int RW  = VW + QB;
	localparam int SQW = 2 * AW - FB;
	localparam int SHW = SQW + AW + 3 - FB;
	localparam int LAT = QB + 8;
	localparam logic [VW-1:0] ONE_V = {{(VW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

	logic signed [VW-1:0] input_low_q, input_high_q, output_low_q, output_high_q;
	logic [2:0]           curve_mode_q;
	logic                 clamp_enable_q;

	logic signed [VW:0]   diff_x, diff_r;
	logic [VW:0]          diff_xn;
	logic [VW-1:0]        mag_x, divisor;
	logic [RW-1:0]        num;
	rrem_pkg::rrem_ctl_t  ctl_in;

	logic [RW-1:0]        rem_c [QB+1];
	logic [QB-1:0]        q_c   [QB+1];
	rrem_pkg::rrem_ctl_t  ctl_c [QB+1];

	logic signed [SHW-1:0] shaped_s4;
	rrem_pkg::rrem_ctl_t   ctl_s4;

	logic                  is_invalid, is_sat, at_bound;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_low_q    <= '0;
			input_high_q   <= ONE_V;
			output_low_q   <= '0;
			output_high_q  <= ONE_V;
			curve_mode_q   <= rrem_pkg::CURVE_LINEAR;
			clamp_enable_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				rrem_pkg::REG_INPUT_LOW:    input_low_q    <= wr_data;
				rrem_pkg::REG_INPUT_HIGH:   input_high_q   <= wr_data;
				rrem_pkg::REG_OUTPUT_LOW:   output_low_q   <= wr_data;
				rrem_pkg::REG_OUTPUT_HIGH:  output_high_q  <= wr_data;
				rrem_pkg::REG_CURVE_MODE:   curve_mode_q   <= wr_data[2:0];
				rrem_pkg::REG_CLAMP_ENABLE: clamp_enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		diff_x  = {sample[VW-1], sample} - {input_low_q[VW-1], input_low_q};
		diff_r  = {input_high_q[VW-1], input_high_q} - {input_low_q[VW-1], input_low_q};
		diff_xn = -diff_x;
		mag_x   = diff_x[VW] ? diff_xn[VW-1:0] : diff_x[VW-1:0];
		divisor = diff_r[VW-1:0];
		num     = {{(QB-FB){1'b0}}, mag_x, {FB{1'b0}}};
		ctl_in.valid   = start;
		ctl_in.neg     = diff_x[VW];
		ctl_in.ovf     = num >= {divisor, {QB{1'b0}}};
		ctl_in.invalid = diff_r[VW] || (diff_r == '0);
	end

	always_ff @(posedge clk) begin
		rem_c[0] <= num;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else begin
			ctl_c[0] <= ctl_in;
		end
	end

	assign q_c[0] = '0;

	for (genvar k = 0; k < QB; k++) begin : g_cell
		rrem_div_cell #(
			.RW    (RW),
			.DW    (VW),
			.QB    (QB),
			.SHIFT (QB - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.divisor (divisor),
			.rem_in  (rem_c[k]),
			.q_in    (q_c[k]),
			.ctl_in  (ctl_c[k]),
			.rem_out (rem_c[k+1]),
			.q_out   (q_c[k+1]),
			.ctl_out (ctl_c[k+1])
		);
	end

	rrem_shape #(
		.FB  (FB),
		.AW  (AW),
		.SQW (SQW),
		.SHW (SHW)
	) u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (curve_mode_q),
		.clamp     (clamp_enable_q),
		.mag_in    (q_c[QB]),
		.ctl_in    (ctl_c[QB]),
		.shaped_s4 (shaped_s4),
		.ctl_s4    (ctl_s4)
	);

	rrem_blend #(
		.VW  (VW),
		.FB  (FB),
		.SHW (SHW)
	) u_blend (
		.clk          (clk),
		.arst_n       (arst_n),
		.out_low      (output_low_q),
		.out_high     (output_high_q),
		.shaped       (shaped_s4),
		.ctl_in       (ctl_s4),
		.done         (done),
		.mapped_value (mapped_value),
		.map_status   (map_status)
	);

	assign is_invalid = done && (map_status == rrem_pkg::STATUS_INVALID);
	assign is_sat     = done && (map_status == rrem_pkg::STATUS_SATURATED);
	assign at_bound   = (mapped_value == {1'b0, {(VW-1){1'b1}}})
		|| (mapped_value == {1'b1, {(VW-1){1'b0}}});

	`RRE_ASSERT_LAT(a_latency, clk, arst_n, start && !busy, LAT, done)
	`RRE_ASSERT_IMP(a_invalid_zero, clk, arst_n, is_invalid, mapped_value == '0)
	`RRE_ASSERT_IMP(a_sat_bound, clk, arst_n, is_sat, at_bound)

endmodule
